/* hdl/padf_pkg.sv */
// Shared types, codes and constants of the phase-angle dimmer with fade.
`timescale 1ns / 1ps
`default_nettype none
package padf_pkg;

  localparam int COMMAND_W     = 2;
  localparam int RATE_W        = 16;
  localparam int TARGET_W      = 7;
  localparam int LEVEL_W       = 21;
  localparam int RELOAD_W      = 10;
  localparam int SCALE_W       = 14;

  localparam int LEVEL_SCALE   = 10000;
  localparam int LEVEL_MAX     = 1100000;
  localparam int FULL_ON_LEVEL = 900000;
  localparam int WINDOW_SPAN   = 20000;

  localparam int RELOAD_RESET  = 100;
  localparam int RATE_RESET    = 10;

  localparam int COUNTER_WIDTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH           = 2;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_TICK        = 2'd0,
    CMD_FADE_UP     = 2'd1,
    CMD_FADE_DOWN   = 2'd2,
    CMD_FADE_TARGET = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_UP     = 2'd1,
    MODE_DOWN   = 2'd2,
    MODE_TARGET = 2'd3
  } fade_mode_t;

  // Decoded item as it waits between the front and the back.
  typedef struct packed {
    command_t            command;
    logic                is_tick;
    logic                zero_cross;
    logic [RATE_W-1:0]   rate;
    logic [LEVEL_W-1:0]  target_scaled;
  } op_t;

  typedef struct packed {
    logic                gate;
    logic [LEVEL_W-1:0]  level;
    fade_mode_t          fade_mode;
  } result_t;

endpackage
`default_nettype wire

/* hdl/phase_angle_dimmer_with_fade_top.sv */
// Top level of the triac phase-angle dimmer with fade.
//
// Usage: items enter through a queue-like port. An item is taken at a rising
// edge with in_push high and in_full low. A command of zero is a tick that
// updates the triac gate from the level and the phase counter (reloaded on a
// zero-cross mark) and applies one fade step; the other commands start a fade
// and latch its rate (and the target of a fade to target). Every item yields
// exactly one result, delivered in order through out_empty and out_pop; a
// transaction completes at an edge with out_pop high and out_empty low.
// The back end executes an item at the edge at which its result enters the
// result queue. Throughput is one item per cycle while the result queue has
// room; the back end updates its state once per item.
// The front end decodes each item into a two-entry operation queue; the back
// end fires whenever that queue holds an item and the two-entry result queue
// has room. When the receiver stalls, the result queue fills, the back end
// stops, the operation queue fills and in_full rises; nothing is lost.
// The counter_reload register is written over cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high, and writes belong to idle periods.
// Reset (synchronous, rst_n low) empties both queues, clears level, counter,
// mode, target and gate, sets the rate to 10 and counter_reload to 100.
`timescale 1ns / 1ps
`default_nettype none
module phase_angle_dimmer_with_fade_top #(
  parameter int COUNTER_WIDTH = padf_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [padf_pkg::COMMAND_W-1:0] in_command,
  input  wire logic                           in_zero_cross,
  input  wire logic [padf_pkg::RATE_W-1:0]    in_rate,
  input  wire logic [padf_pkg::TARGET_W-1:0]  in_target,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic                                out_gate,
  output logic [padf_pkg::LEVEL_W-1:0]        out_level,
  output logic [1:0]                          out_fade_mode,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [padf_pkg::RELOAD_W-1:0]  cfg_data
);

  padf_pkg::op_t     front_op;
  padf_pkg::op_t     queued_op;
  padf_pkg::result_t back_result;
  padf_pkg::result_t head_result;
  logic              op_full, op_empty;
  logic              res_full;
  logic              back_fire;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;

  padf_front u_front (
    .command    (in_command),
    .zero_cross (in_zero_cross),
    .rate       (in_rate),
    .target     (in_target),
    .op         (front_op)
  );

  padf_fifo #(
    .WIDTH ($bits(padf_pkg::op_t)),
    .DEPTH (padf_pkg::QUEUE_DEPTH)
  ) u_op_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (front_op),
    .full    (op_full),
    .rd_en   (back_fire),
    .rd_data (queued_op),
    .empty   (op_empty)
  );

  assign in_full = op_full;

  // The back end executes the oldest operation whenever its result has room.
  assign back_fire = !op_empty && !res_full;

  padf_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_reload (cfg_data),
    .fire       (back_fire),
    .op         (queued_op),
    .result     (back_result)
  );

  padf_fifo #(
    .WIDTH ($bits(padf_pkg::result_t)),
    .DEPTH (padf_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (back_fire),
    .wr_data (back_result),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (head_result),
    .empty   (out_empty)
  );

  assign out_gate      = head_result.gate;
  assign out_level     = head_result.level;
  assign out_fade_mode = head_result.fade_mode;

  // The level reported never leaves its clamped range.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_level <= padf_pkg::LEVEL_W'(padf_pkg::LEVEL_MAX)))
    else $error("result level above upper limit");

  // An accepted transaction is waiting in the operation queue in the cycle after it is taken.
  a_op_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !op_empty)
    else $error("accepted item missing from operation queue");

  // A fade command reports its own mode in its result.
  a_cmd_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (back_fire && !queued_op.is_tick) |->
      (back_result.fade_mode == padf_pkg::fade_mode_t'(queued_op.command)))
    else $error("fade command result carries wrong mode");

endmodule
`default_nettype wire

/* hdl/padf_fifo.sv */
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps
`default_nettype none
module padf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == NW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + NW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* hdl/padf_front.sv */
// Front end: classifies an incoming item and scales the fade target.
`timescale 1ns / 1ps
`default_nettype none
module padf_front (
  input  wire logic [padf_pkg::COMMAND_W-1:0] command,
  input  wire logic                           zero_cross,
  input  wire logic [padf_pkg::RATE_W-1:0]    rate,
  input  wire logic [padf_pkg::TARGET_W-1:0]  target,
  output padf_pkg::op_t                       op
);

  logic [padf_pkg::LEVEL_W-1:0] target_ext;

  assign target_ext = {{(padf_pkg::LEVEL_W - padf_pkg::TARGET_W){1'b0}}, target};

  always_comb begin
    op.command       = padf_pkg::command_t'(command);
    op.is_tick       = (padf_pkg::command_t'(command) == padf_pkg::CMD_TICK);
    op.zero_cross    = zero_cross;
    op.rate          = rate;
    // A target of up to 127 whole units still fits the level width.
    op.target_scaled = target_ext * padf_pkg::LEVEL_W'(padf_pkg::LEVEL_SCALE);
  end

endmodule
`default_nettype wire

/* hdl/padf_back.sv */
// Back end: holds the dimmer state and executes one decoded item per cycle while fire is high.
`timescale 1ns / 1ps
`default_nettype none
module padf_back #(
  parameter int COUNTER_WIDTH = padf_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [padf_pkg::RELOAD_W-1:0] cfg_reload,
  input  wire logic                          fire,
  input  padf_pkg::op_t                      op,
  output padf_pkg::result_t                  result
);

  localparam int LW = padf_pkg::LEVEL_W;
  localparam int SW = COUNTER_WIDTH + padf_pkg::SCALE_W;

  logic [padf_pkg::RELOAD_W-1:0] reload_r;
  logic [LW-1:0]                 level_r, level_nxt;
  logic [COUNTER_WIDTH-1:0]      pc_r, pc_nxt;
  padf_pkg::fade_mode_t          mode_r, mode_nxt;
  logic [LW-1:0]                 tgt_r, tgt_nxt;
  logic [padf_pkg::RATE_W-1:0]   rate_r, rate_nxt;
  logic                          gate_r, gate_nxt;

  logic [COUNTER_WIDTH+padf_pkg::RELOAD_W-1:0] reload_wide;
  logic [COUNTER_WIDTH-1:0] pc_eff;
  logic [SW-1:0]            scaled;
  logic [SW-1:0]            win_lo, win_hi;
  logic [LW:0]              sum_up;
  logic [LW-1:0]            lv_up, lv_down, lv_tgt;
  logic [LW:0]              l_plus, t_plus;

  assign reload_wide = {{COUNTER_WIDTH{1'b0}}, reload_r};
  assign pc_eff      = op.zero_cross ? reload_wide[COUNTER_WIDTH-1:0] : pc_r;
  assign scaled      = {{padf_pkg::SCALE_W{1'b0}}, pc_eff} * SW'(padf_pkg::LEVEL_SCALE);
  assign win_lo      = SW'(level_r);
  assign win_hi      = SW'(level_r) + SW'(padf_pkg::WINDOW_SPAN);

  assign sum_up  = {1'b0, level_r} + (LW + 1)'(rate_r);
  assign lv_up   = (sum_up > (LW + 1)'(padf_pkg::LEVEL_MAX)) ?
                   LW'(padf_pkg::LEVEL_MAX) : sum_up[LW-1:0];
  assign lv_down = (LW'(rate_r) >= level_r) ? '0 : level_r - LW'(rate_r);
  assign lv_tgt  = (level_r < tgt_r) ? lv_up : ((level_r > tgt_r) ? lv_down : level_r);
  assign l_plus  = {1'b0, lv_tgt} + (LW + 1)'(padf_pkg::LEVEL_SCALE);
  assign t_plus  = {1'b0, tgt_r} + (LW + 1)'(padf_pkg::LEVEL_SCALE);

  always_comb begin
    level_nxt = level_r;
    pc_nxt    = pc_r;
    mode_nxt  = mode_r;
    tgt_nxt   = tgt_r;
    rate_nxt  = rate_r;
    gate_nxt  = gate_r;
    if (op.is_tick) begin
      if (level_r == '0) begin
        gate_nxt = 1'b0;
      end else if (level_r > LW'(padf_pkg::FULL_ON_LEVEL)) begin
        gate_nxt = 1'b1;
      end else begin
        gate_nxt = (scaled >= win_lo) && (scaled <= win_hi);
      end
      pc_nxt = (pc_eff != '0) ? pc_eff - COUNTER_WIDTH'(1) : pc_eff;
      unique case (mode_r)
        padf_pkg::MODE_UP: begin
          if (level_r < LW'(padf_pkg::FULL_ON_LEVEL)) level_nxt = lv_up;
          else mode_nxt = padf_pkg::MODE_IDLE;
        end
        padf_pkg::MODE_DOWN: begin
          if (level_r > LW'(padf_pkg::LEVEL_SCALE)) level_nxt = lv_down;
          else mode_nxt = padf_pkg::MODE_IDLE;
        end
        padf_pkg::MODE_TARGET: begin
          level_nxt = lv_tgt;
          if ((l_plus > {1'b0, tgt_r}) && ({1'b0, lv_tgt} < t_plus)) begin
            mode_nxt = padf_pkg::MODE_IDLE;
          end
        end
        default: begin
        end
      endcase
    end else begin
      mode_nxt = padf_pkg::fade_mode_t'(op.command);
      rate_nxt = op.rate;
      if (op.command == padf_pkg::CMD_FADE_TARGET) tgt_nxt = op.target_scaled;
    end
  end

  always_comb begin
    result.gate      = gate_nxt;
    result.level     = level_nxt;
    result.fade_mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= padf_pkg::RELOAD_W'(padf_pkg::RELOAD_RESET);
    end else if (cfg_we) begin
      reload_r <= cfg_reload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      pc_r    <= '0;
      mode_r  <= padf_pkg::MODE_IDLE;
      tgt_r   <= '0;
      rate_r  <= padf_pkg::RATE_W'(padf_pkg::RATE_RESET);
      gate_r  <= 1'b0;
    end else if (fire) begin
      level_r <= level_nxt;
      pc_r    <= pc_nxt;
      mode_r  <= mode_nxt;
      tgt_r   <= tgt_nxt;
      rate_r  <= rate_nxt;
      gate_r  <= gate_nxt;
    end
  end

endmodule
`default_nettype wire
